@@ hw/rtl/swlap_pkg.sv @@
// shared types, codes and constants for the stopwatch with lap memory
`default_nettype none

package swlap_pkg;

    localparam int LAPS   = 8;
    localparam int SLOT_W = 3;
    localparam int VIEW_W = 4;

    localparam int EL_W   = 17;
    localparam int Q_W    = 8;
    localparam int R_W    = 10;

    // floor(x / 1000) == (x * DIV_MUL) >> DIV_SHIFT for every 17-bit x
    localparam int DIV_SHIFT = 27;
    localparam int DIV_MUL_W = 18;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'((2 ** DIV_SHIFT) / 1000 + 1);

    localparam logic [9:0] SUB_UNITS   = 10'd1000;
    localparam logic [5:0] SEC_PER_MIN = 6'd60;
    localparam logic [5:0] MIN_PER_HR  = 6'd60;
    localparam logic [6:0] HOURS_WRAP  = 7'd100;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_BTN_A = 2'd1;
    localparam logic [1:0] CMD_BTN_B = 2'd2;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_REVIEW = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;
    localparam logic [1:0] MODE_PAUSE  = 2'd3;

    typedef struct packed {
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [9:0] millis;
        logic [9:0] micros;
    } time_t;

    typedef struct packed {
        logic [1:0]        mode;
        time_t             now;
        logic [VIEW_W-1:0] view_slot;
        logic [SLOT_W-1:0] write_slot;
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/stopwatch_with_lap_memory.sv @@
// stopwatch with lap memory: top level with input register and result handshake
// an accepted input beat passes the input register, then the state registers, to its result beat on m_
// throughput: one beat per cycle while m_ready does not stall the result; the state update loop sets the rate
// the state registers double as the result register, m_valid marks it full
// s_ready stays high while the result is taken, the result register is empty or the input register is empty
// reset (aresetn low, synchronous): idle, time zero, slots zero, lap store zero
`default_nettype none

module stopwatch_with_lap_memory (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [16:0] s_elapsed_us,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_mode,
    output logic [6:0]       m_hours,
    output logic [5:0]       m_minutes,
    output logic [5:0]       m_seconds,
    output logic [9:0]       m_milliseconds,
    output logic [9:0]       m_microseconds,
    output logic [3:0]       m_lap_number,
    output logic [2:0]       m_laps_stored
);

    logic                          in_valid_reg;
    logic [1:0]                    cmd_reg;
    logic [swlap_pkg::Q_W-1:0]     q_reg;
    logic [swlap_pkg::R_W-1:0]     r_reg;
    logic [swlap_pkg::Q_W-1:0]     q_next;
    logic [swlap_pkg::R_W-1:0]     r_next;
    logic                          out_valid_reg;
    logic                          step;
    swlap_pkg::status_t            status;

    swlap_split u_split (
        .elapsed_us (s_elapsed_us),
        .ms_part    (q_next),
        .us_part    (r_next)
    );

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input beat payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_command;
            q_reg   <= q_next;
            r_reg   <= r_next;
        end
    end

    swlap_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .command (cmd_reg),
        .ms_part (q_reg),
        .us_part (r_reg),
        .status  (status)
    );

    assign m_valid        = out_valid_reg;
    assign m_mode         = status.mode;
    assign m_hours        = status.now.hours;
    assign m_minutes      = status.now.minutes;
    assign m_seconds      = status.now.seconds;
    assign m_milliseconds = status.now.millis;
    assign m_microseconds = status.now.micros;
    assign m_lap_number   = status.view_slot;
    assign m_laps_stored  = status.write_slot;

    a_time_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hours < 7'd100 && m_minutes < 6'd60 && m_seconds < 6'd60 &&
                     m_milliseconds < 10'd1000 && m_microseconds < 10'd1000))
        else $error("shown time out of range");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_mode == swlap_pkg::MODE_IDLE) |->
        (m_hours == 7'd0 && m_minutes == 6'd0 && m_seconds == 6'd0 &&
         m_milliseconds == 10'd0 && m_microseconds == 10'd0))
        else $error("idle with nonzero time");

    a_view_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lap_number <= {1'b0, m_laps_stored} + 4'd1))
        else $error("review position past stored laps");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled with empty input register");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("processed beat left no result");

endmodule

`default_nettype wire

@@ hw/rtl/swlap_split.sv @@
// splits elapsed microseconds into milliseconds and leftover microseconds
`default_nettype none

module swlap_split (
    input  wire logic [swlap_pkg::EL_W-1:0] elapsed_us,
    output logic      [swlap_pkg::Q_W-1:0]  ms_part,
    output logic      [swlap_pkg::R_W-1:0]  us_part
);

    localparam int PROD_W = swlap_pkg::EL_W + swlap_pkg::DIV_MUL_W;

    logic [PROD_W-1:0]             prod;
    logic [swlap_pkg::EL_W-1:0]    q_ext;
    logic [swlap_pkg::EL_W-1:0]    diff;

    assign prod    = PROD_W'(elapsed_us) * PROD_W'(swlap_pkg::DIV_MUL);
    assign ms_part = prod[swlap_pkg::DIV_SHIFT +: swlap_pkg::Q_W];
    assign q_ext   = swlap_pkg::EL_W'(ms_part);
    // q * 1000 as q*1024 - q*16 - q*8
    assign diff    = elapsed_us - ((q_ext << 10) - (q_ext << 4) - (q_ext << 3));
    assign us_part = diff[swlap_pkg::R_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/swlap_core.sv @@
// mode control, time counter with carries, and lap store
`default_nettype none

module swlap_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        step,
    input  wire logic [1:0]                  command,
    input  wire logic [swlap_pkg::Q_W-1:0]   ms_part,
    input  wire logic [swlap_pkg::R_W-1:0]   us_part,
    output swlap_pkg::status_t               status
);

    logic [1:0]                      mode_reg, mode_next;
    swlap_pkg::time_t                time_reg, time_next;
    logic [swlap_pkg::SLOT_W-1:0]    write_reg, write_next;
    logic [swlap_pkg::VIEW_W-1:0]    view_reg, view_next;
    swlap_pkg::time_t                lap_store_reg [swlap_pkg::LAPS];

    swlap_pkg::time_t                adv, time_a, lap_rd;
    logic [10:0]                     us_sum, ms_sum;
    logic                            c_us, c_ms, c_s, c_m;
    logic [5:0]                      sec_sum, min_sum;
    logic [6:0]                      hr_sum;
    logic [swlap_pkg::VIEW_W-1:0]    view_adj, view_inc;
    logic                            store_en;

    // time advance with carries
    always_comb begin
        us_sum = {1'b0, time_reg.micros} + {1'b0, us_part};
        c_us   = us_sum >= {1'b0, swlap_pkg::SUB_UNITS};
        adv.micros = c_us ? 10'(us_sum - {1'b0, swlap_pkg::SUB_UNITS}) : us_sum[9:0];

        ms_sum = {1'b0, time_reg.millis} + {3'b0, ms_part} + {10'b0, c_us};
        c_ms   = ms_sum >= {1'b0, swlap_pkg::SUB_UNITS};
        adv.millis = c_ms ? 10'(ms_sum - {1'b0, swlap_pkg::SUB_UNITS}) : ms_sum[9:0];

        sec_sum = time_reg.seconds + {5'b0, c_ms};
        c_s     = sec_sum == swlap_pkg::SEC_PER_MIN;
        adv.seconds = c_s ? 6'd0 : sec_sum;

        min_sum = time_reg.minutes + {5'b0, c_s};
        c_m     = min_sum == swlap_pkg::MIN_PER_HR;
        adv.minutes = c_m ? 6'd0 : min_sum;

        hr_sum    = time_reg.hours + {6'b0, c_m};
        adv.hours = hr_sum;
        if (hr_sum == swlap_pkg::HOURS_WRAP) begin
            adv = '0;
        end
    end

    assign time_a   = (mode_reg == swlap_pkg::MODE_RUN) ? adv : time_reg;
    assign view_adj = (view_reg > {1'b0, write_reg}) ? '0 : view_reg;
    assign view_inc = view_adj + 1'b1;
    assign lap_rd   = (view_adj < swlap_pkg::VIEW_W'(swlap_pkg::LAPS))
                    ? lap_store_reg[view_adj[swlap_pkg::SLOT_W-1:0]] : '0;

    always_comb begin
        mode_next  = mode_reg;
        time_next  = time_a;
        write_next = write_reg;
        view_next  = view_reg;
        store_en   = 1'b0;
        unique case (command)
            swlap_pkg::CMD_BTN_A: begin
                unique case (mode_reg)
                    swlap_pkg::MODE_IDLE: begin
                        write_next = '0;
                        view_next  = swlap_pkg::VIEW_W'(1);
                        mode_next  = swlap_pkg::MODE_RUN;
                    end
                    swlap_pkg::MODE_REVIEW: begin
                        time_next = lap_rd;
                        view_next = view_inc;
                    end
                    swlap_pkg::MODE_RUN: begin
                        mode_next = swlap_pkg::MODE_PAUSE;
                    end
                    default: begin
                        mode_next = swlap_pkg::MODE_RUN;
                    end
                endcase
            end
            swlap_pkg::CMD_BTN_B: begin
                unique case (mode_reg)
                    swlap_pkg::MODE_IDLE: begin
                        time_next = lap_rd;
                        view_next = view_inc;
                        mode_next = swlap_pkg::MODE_REVIEW;
                    end
                    swlap_pkg::MODE_REVIEW: begin
                        view_next = '0;
                        time_next = '0;
                        mode_next = swlap_pkg::MODE_IDLE;
                    end
                    swlap_pkg::MODE_RUN: begin
                        if (write_reg < swlap_pkg::SLOT_W'(swlap_pkg::LAPS - 1)) begin
                            store_en   = 1'b1;
                            write_next = write_reg + 1'b1;
                        end
                    end
                    default: begin
                        store_en  = {1'b0, write_reg} < swlap_pkg::VIEW_W'(swlap_pkg::LAPS);
                        view_next = '0;
                        time_next = '0;
                        mode_next = swlap_pkg::MODE_IDLE;
                    end
                endcase
            end
            default: begin
                // tick, and the unused code, only advance the time, and that only in run mode
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= swlap_pkg::MODE_IDLE;
            time_reg  <= '0;
            write_reg <= '0;
            view_reg  <= '0;
            for (int i = 0; i < swlap_pkg::LAPS; i++) begin
                lap_store_reg[i] <= '0;
            end
        end else if (step) begin
            mode_reg  <= mode_next;
            time_reg  <= time_next;
            write_reg <= write_next;
            view_reg  <= view_next;
            if (store_en) begin
                lap_store_reg[write_reg] <= time_a;
            end
        end
    end

    assign status.mode       = mode_reg;
    assign status.now        = time_reg;
    assign status.view_slot  = view_reg;
    assign status.write_slot = write_reg;

endmodule

`default_nettype wire
